### hdl/prc_pkg.sv
package prc_pkg;

	localparam int COORD_WIDTH       = 24;
	localparam int ANGLE_WIDTH       = 16;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int GUARD_BITS        = 4;
	localparam int ZW                = 32;
	// offset sign bit, guard bits and cordic growth
	localparam int XW                = COORD_WIDTH + GUARD_BITS + 3;
	localparam int GAIN_SHIFT        = 32 + GUARD_BITS;

	localparam logic [31:0] GAIN_INV = 32'd2608131496;

	localparam logic [31:0] ATAN_TURNS [32] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81,
		32'd41,        32'd20,        32'd10,        32'd5,
		32'd3,         32'd1,         32'd1,         32'd0
	};

	typedef enum logic [1:0] {
		QUAD_0,
		QUAD_1,
		QUAD_2,
		QUAD_3
	} quad_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] point_x;
		logic signed [COORD_WIDTH-1:0] point_y;
		logic signed [COORD_WIDTH-1:0] pivot_x;
		logic signed [COORD_WIDTH-1:0] pivot_y;
		logic signed [ANGLE_WIDTH-1:0] turn_angle;
	} in_item_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] rotated_x;
		logic signed [COORD_WIDTH-1:0] rotated_y;
		logic                          clipped;
	} out_item_t;

	typedef struct packed {
		logic signed [XW-1:0]          x;
		logic signed [XW-1:0]          y;
		logic signed [ZW-1:0]          z;
		logic signed [COORD_WIDTH-1:0] cx;
		logic signed [COORD_WIDTH-1:0] cy;
	} cordic_t;

endpackage

### hdl/prc_cordic_stage.sv
module prc_cordic_stage #(
	parameter int STAGE_IDX = 0
) (
	input  logic             clk,
	input  logic             en,
	input  prc_pkg::cordic_t rot_in,
	output prc_pkg::cordic_t rot_out
);

	prc_pkg::cordic_t rot_s1;
	prc_pkg::cordic_t rot_d;
	logic signed [prc_pkg::XW-1:0] xs;
	logic signed [prc_pkg::XW-1:0] ys;
	logic signed [prc_pkg::ZW-1:0] step;

	always_comb begin
		xs    = rot_in.x >>> STAGE_IDX;
		ys    = rot_in.y >>> STAGE_IDX;
		step  = signed'(prc_pkg::ATAN_TURNS[STAGE_IDX]);
		rot_d = rot_in;
		if (!rot_in.z[prc_pkg::ZW-1]) begin
			rot_d.x = rot_in.x - ys;
			rot_d.y = rot_in.y + xs;
			rot_d.z = rot_in.z - step;
		end else begin
			rot_d.x = rot_in.x + ys;
			rot_d.y = rot_in.y - xs;
			rot_d.z = rot_in.z + step;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_s1 <= rot_d;
		end
	end

	assign rot_out = rot_s1;

endmodule

### hdl/prc_gain_fix.sv
module prc_gain_fix (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic signed [prc_pkg::XW-1:0]          vin,
	input  logic signed [prc_pkg::COORD_WIDTH-1:0] cin,
	output logic signed [prc_pkg::COORD_WIDTH-1:0] result,
	output logic                                   clip
);

	localparam int XW   = prc_pkg::XW;
	localparam int CW   = prc_pkg::COORD_WIDTH;
	localparam int GS   = prc_pkg::GAIN_SHIFT;
	localparam int LO_W = XW / 2;
	localparam int HI_W = XW - LO_W;
	localparam int PW   = XW + 33;
	localparam int RW   = PW - GS;
	localparam int NW   = RW + 1;
	localparam int SW   = RW + 2;

	logic                 neg_s1;
	logic [XW-1:0]        mag_s1;
	logic signed [CW-1:0] c_s1;

	logic [HI_W+31:0]     pa_s2;
	logic [LO_W+31:0]     pb_s2;
	logic                 neg_s2;
	logic signed [CW-1:0] c_s2;

	logic signed [SW-1:0] sum_s3;

	logic signed [CW-1:0] res_s4;
	logic                 clip_s4;

	logic [PW-1:0]        full;
	logic [RW-1:0]        rmag;
	logic signed [NW-1:0] rs;
	logic signed [SW-1:0] sum_d;
	logic                 in_range;
	logic signed [CW-1:0] res_d;

	always_comb begin
		full = (PW'(pa_s2) << LO_W) + PW'(pb_s2) + (PW'(1) << (GS - 1));
		rmag = full[PW-1:GS];
		rs   = signed'({1'b0, rmag});
		if (neg_s2) begin
			rs = -rs;
		end
		sum_d = SW'(rs) + SW'(c_s2);
	end

	always_comb begin
		in_range = (&sum_s3[SW-1:CW-1]) || !(|sum_s3[SW-1:CW-1]);
		if (in_range) begin
			res_d = sum_s3[CW-1:0];
		end else if (sum_s3[SW-1]) begin
			res_d = {1'b1, {(CW-1){1'b0}}};
		end else begin
			res_d = {1'b0, {(CW-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1  <= vin[XW-1];
			mag_s1  <= vin[XW-1] ? XW'(-vin) : XW'(vin);
			c_s1    <= cin;
			pa_s2   <= (HI_W+32)'(mag_s1[XW-1:LO_W]) * (HI_W+32)'(prc_pkg::GAIN_INV);
			pb_s2   <= (LO_W+32)'(mag_s1[LO_W-1:0]) * (LO_W+32)'(prc_pkg::GAIN_INV);
			neg_s2  <= neg_s1;
			c_s2    <= c_s1;
			sum_s3  <= sum_d;
			res_s4  <= res_d;
			clip_s4 <= !in_range;
		end
	end

	assign result = res_s4;
	assign clip   = clip_s4;

endmodule

### hdl/point_rotate_about_center.sv
// throughput: one item per cycle while the skid is empty; one register stage per cordic micro-rotation,
// then a two-part split multiply for the gain, rounding and saturation
// a skid register takes a result that waits; input closes while the skid is full
// reset clears all valid bits; data registers are not reset
module point_rotate_about_center #(
	parameter int CORDIC_STAGES = prc_pkg::CORDIC_STAGES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  prc_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output prc_pkg::out_item_t out_data
);

	localparam int CW = prc_pkg::COORD_WIDTH;
	localparam int AW = prc_pkg::ANGLE_WIDTH;
	localparam int XW = prc_pkg::XW;
	localparam int ZW = prc_pkg::ZW;
	localparam int NS = CORDIC_STAGES + 5;

	logic [NS-1:0]      vld_q;
	logic               skid_vld_q;
	prc_pkg::out_item_t skid_q;
	prc_pkg::out_item_t last_item;
	logic               en_pipe;

	prc_pkg::cordic_t   rot_s1;
	prc_pkg::cordic_t   rot_d;
	prc_pkg::cordic_t   rot_st [CORDIC_STAGES+1];

	logic [AW-1:0]        u;
	logic [AW-1:0]        qsum;
	prc_pkg::quad_t       quad;
	logic [AW-1:0]        diff;
	logic signed [ZW-1:0] zext;
	logic signed [CW:0]   dx;
	logic signed [CW:0]   dy;
	logic signed [XW-1:0] x0;
	logic signed [XW-1:0] y0;

	logic signed [CW-1:0] res_x;
	logic signed [CW-1:0] res_y;
	logic                 clip_x;
	logic                 clip_y;

	assign en_pipe  = !skid_vld_q;
	assign in_ready = en_pipe;

	// quadrant pre-rotation and residual angle
	always_comb begin
		u    = in_data.turn_angle;
		qsum = u + (AW'(1) << (AW - 3));
		quad = prc_pkg::quad_t'(qsum[AW-1 -: 2]);
		diff = u - {qsum[AW-1 -: 2], {(AW-2){1'b0}}};
		zext = ZW'(signed'(diff));
		dx   = (CW+1)'(in_data.point_x) - (CW+1)'(in_data.pivot_x);
		dy   = (CW+1)'(in_data.point_y) - (CW+1)'(in_data.pivot_y);
		x0   = XW'(dx) <<< prc_pkg::GUARD_BITS;
		y0   = XW'(dy) <<< prc_pkg::GUARD_BITS;

		rot_d.z  = zext <<< (ZW - AW);
		rot_d.cx = in_data.pivot_x;
		rot_d.cy = in_data.pivot_y;
		unique case (quad)
			prc_pkg::QUAD_1: begin
				rot_d.x = -y0;
				rot_d.y = x0;
			end
			prc_pkg::QUAD_2: begin
				rot_d.x = -x0;
				rot_d.y = -y0;
			end
			prc_pkg::QUAD_3: begin
				rot_d.x = y0;
				rot_d.y = -x0;
			end
			default: begin
				rot_d.x = x0;
				rot_d.y = y0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_pipe) begin
			rot_s1 <= rot_d;
		end
	end

	assign rot_st[0] = rot_s1;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		prc_cordic_stage #(
			.STAGE_IDX(i)
		) u_stage (
			.clk    (clk),
			.en     (en_pipe),
			.rot_in (rot_st[i]),
			.rot_out(rot_st[i+1])
		);
	end

	prc_gain_fix u_gain_x (
		.clk   (clk),
		.en    (en_pipe),
		.vin   (rot_st[CORDIC_STAGES].x),
		.cin   (rot_st[CORDIC_STAGES].cx),
		.result(res_x),
		.clip  (clip_x)
	);

	prc_gain_fix u_gain_y (
		.clk   (clk),
		.en    (en_pipe),
		.vin   (rot_st[CORDIC_STAGES].y),
		.cin   (rot_st[CORDIC_STAGES].cy),
		.result(res_y),
		.clip  (clip_y)
	);

	always_comb begin
		last_item.rotated_x = res_x;
		last_item.rotated_y = res_y;
		last_item.clipped   = clip_x | clip_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			skid_vld_q <= 1'b0;
		end else begin
			if (en_pipe) begin
				vld_q <= {vld_q[NS-2:0], in_valid};
			end
			if (skid_vld_q) begin
				if (out_ready) begin
					skid_vld_q <= 1'b0;
				end
			end else if (vld_q[NS-1] && !out_ready) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	// stalled item moves aside while the pipeline advances
	always_ff @(posedge clk) begin
		if (!skid_vld_q && vld_q[NS-1] && !out_ready) begin
			skid_q <= last_item;
		end
	end

	assign out_valid = skid_vld_q | vld_q[NS-1];
	assign out_data  = skid_vld_q ? skid_q : last_item;

endmodule

### tb/tb.sv
module tb;

	localparam int STAGES = prc_pkg::CORDIC_STAGES_DEF;
	localparam int CW = prc_pkg::COORD_WIDTH;
	localparam int AW = prc_pkg::ANGLE_WIDTH;
	localparam int RANDOM_POINTS = 1800;
	localparam int TAIL_ITEMS = 150;
	localparam longint GAIN_COMP = 64'd2608131496;
	localparam logic [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

	localparam longint ARCTAN_STEP [32] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
		83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
		81, 41, 20, 10, 5, 3, 1, 1, 0
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	prc_pkg::in_item_t  in_data = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	prc_pkg::out_item_t out_data;

	prc_pkg::in_item_t  pending_points[$];
	prc_pkg::out_item_t rotations_due[$];

	int  sent_total = 0;
	int  taken_count = 0;
	int  checked_count = 0;
	int  clipped_count = 0;
	int  fail_count = 0;
	bit  in_took = 1'b0;
	int  in_gap = 0;
	int  in_calm = 0;
	int  out_gap = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;

	point_rotate_about_center dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#10000000;
		$display("point_rotate_about_center test failed");
		$finish;
	end

	// round(v * gain / 2^(32+guard)), ties away from zero
	function automatic longint scale_gain(input longint v);
		logic [63:0]  mag;
		logic [127:0] prod;
		longint       r;
		mag = (v < 0) ? -v : v;
		prod = 128'(mag) * 128'(GAIN_COMP) + (128'd1 << (prc_pkg::GAIN_SHIFT - 1));
		r = longint'(prod >> prc_pkg::GAIN_SHIFT);
		return (v < 0) ? -r : r;
	endfunction

	function automatic longint clamp_coord(input longint v, output bit hit);
		longint top;
		top = (longint'(1) <<< (CW - 1)) - 1;
		hit = 1'b0;
		if (v > top) begin
			hit = 1'b1;
			return top;
		end
		if (v < -top - 1) begin
			hit = 1'b1;
			return -top - 1;
		end
		return v;
	endfunction

	function automatic prc_pkg::out_item_t rotate_about_pivot(input prc_pkg::in_item_t it);
		longint px, py, cx, cy, x0, y0, x, y, z, xs, ys, res;
		logic [AW-1:0] u, ur;
		logic [1:0] q;
		bit hx, hy;
		prc_pkg::out_item_t o;
		px = longint'(it.point_x);
		py = longint'(it.point_y);
		cx = longint'(it.pivot_x);
		cy = longint'(it.pivot_y);
		u = it.turn_angle;
		ur = u + AW'(1 << (AW - 3));
		q = ur[AW-1 -: 2];
		res = longint'(u) - longint'(q) * (longint'(1) <<< (AW - 2));
		if (res >= (longint'(1) <<< (AW - 1)))
			res -= longint'(1) <<< AW;
		z = res * (longint'(1) <<< (prc_pkg::ZW - AW));
		x0 = (px - cx) * (longint'(1) <<< prc_pkg::GUARD_BITS);
		y0 = (py - cy) * (longint'(1) <<< prc_pkg::GUARD_BITS);
		case (prc_pkg::quad_t'(q))
			prc_pkg::QUAD_1: begin
				x = -y0;
				y = x0;
			end
			prc_pkg::QUAD_2: begin
				x = -x0;
				y = -y0;
			end
			prc_pkg::QUAD_3: begin
				x = y0;
				y = -x0;
			end
			default: begin
				x = x0;
				y = y0;
			end
		endcase
		for (int i = 0; i < STAGES; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys;
				y += xs;
				z -= ARCTAN_STEP[i];
			end else begin
				x += ys;
				y -= xs;
				z += ARCTAN_STEP[i];
			end
		end
		x = clamp_coord(scale_gain(x) + cx, hx);
		y = clamp_coord(scale_gain(y) + cy, hy);
		o.rotated_x = x[CW-1:0];
		o.rotated_y = y[CW-1:0];
		o.clipped = hx | hy;
		return o;
	endfunction

	task automatic add_point(input logic [CW-1:0] px, input logic [CW-1:0] py,
			input logic [CW-1:0] cx, input logic [CW-1:0] cy,
			input logic [AW-1:0] ang);
		prc_pkg::in_item_t it;
		it.point_x = px;
		it.point_y = py;
		it.pivot_x = cx;
		it.pivot_y = cy;
		it.turn_angle = ang;
		pending_points.insert(pending_points.size(), it);
		sent_total++;
	endtask

	// input side: one item per handshake, random idle bursts
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_took) begin
			end else if (in_gap > 0) begin
				in_valid <= 1'b0;
				in_gap--;
			end else if (pending_points.size() == 0) begin
				in_valid <= 1'b0;
			end else if (pending_points.size() > TAIL_ITEMS && in_calm == 0 &&
					$urandom_range(0, 7) == 0) begin
				in_valid <= 1'b0;
				in_gap = $urandom_range(0, 13);
				in_calm = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : 0;
			end else begin
				in_data <= pending_points.pop_front();
				in_valid <= 1'b1;
				if (in_calm > 0)
					in_calm--;
			end
		end
	end

	// output side: random stalls plus one long hold-off to back up the pipeline
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (!hold_done && taken_count >= 500) begin
				hold_done = 1'b1;
				hold_left = 99;
				out_ready <= 1'b0;
			end else if (out_gap > 0) begin
				out_ready <= 1'b0;
				out_gap--;
			end else if (pending_points.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				out_gap = $urandom_range(0, 13);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		prc_pkg::out_item_t want;
		if (arst_n) begin
			in_took = in_valid && in_ready;
			if (in_valid && in_ready) begin
				rotations_due.insert(rotations_due.size(), rotate_about_pivot(in_data));
				taken_count++;
			end
			if (out_valid && out_ready) begin
				if (rotations_due.size() == 0) begin
					$error("rotated point with no item pending");
					fail_count++;
				end else begin
					want = rotations_due.pop_front();
					checked_count++;
					if (want.clipped)
						clipped_count++;
					if (out_data.rotated_x !== want.rotated_x) begin
						$error("rotated_x expected %0d got %0d", want.rotated_x,
							out_data.rotated_x);
						fail_count++;
					end
					if (out_data.rotated_y !== want.rotated_y) begin
						$error("rotated_y expected %0d got %0d", want.rotated_y,
							out_data.rotated_y);
						fail_count++;
					end
					if (out_data.clipped !== want.clipped) begin
						$error("clipped expected %0d got %0d", want.clipped,
							out_data.clipped);
						fail_count++;
					end
				end
			end
		end
	end

	initial begin
		logic [CW-1:0] px, py, cx, cy;
		logic [AW-1:0] ang;
		int mode;

		// quadrant edges, half turn, extremes and saturation
		add_point(0, 0, 0, 0, 0);
		add_point(256, 0, 0, 0, 16384);
		add_point(256, 0, 0, 0, 16'h8000);
		add_point(256, 0, 0, 0, 32767);
		add_point(256, 0, 0, 0, 8192);
		add_point(256, 0, 0, 0, 8191);
		add_point(256, 0, 0, 0, -16'sd8192);
		add_point(256, 0, 0, 0, -16'sd8193);
		add_point(C_MAX, C_MAX, C_MIN, C_MIN, 0);
		add_point(C_MAX, C_MAX, C_MIN, C_MIN, 8192);
		add_point(C_MIN, C_MIN, C_MAX, C_MAX, 16'h8000);
		add_point(C_MIN, C_MIN, C_MAX, C_MAX, 0);
		add_point(C_MAX, C_MIN, C_MIN, C_MAX, 16384);
		add_point(C_MIN, C_MAX, C_MAX, C_MIN, -16'sd16384);
		add_point(C_MAX, C_MAX, C_MAX, C_MAX, 12345);
		add_point(C_MIN, C_MIN, C_MIN, C_MIN, 16'hFFFF);
		add_point(-24'sd1, -24'sd1, 0, 0, 24576);
		add_point(1, -24'sd1, 0, 0, -16'sd24576);
		add_point(1000, -24'sd2000, 300, 400, 4096);
		add_point(C_MAX, 0, 0, 0, 16'h8000);
		add_point(C_MIN, 0, 0, 0, 16'h8000);
		add_point(0, C_MIN, 0, 0, 16384);

		for (int n = 0; n < RANDOM_POINTS; n++) begin
			mode = $urandom_range(0, 9);
			px = CW'($urandom);
			py = CW'($urandom);
			cx = CW'($urandom);
			cy = CW'($urandom);
			ang = AW'($urandom);
			case (mode)
				4, 5: begin
					px = cx + CW'($signed(13'($urandom)));
					py = cy + CW'($signed(13'($urandom)));
				end
				6: begin
					ang = AW'($urandom_range(0, 7) * 8192 + $urandom_range(0, 4) - 2);
				end
				7: begin
					cx = $urandom_range(0, 1) ? C_MAX - CW'($urandom_range(0, 4095))
						: C_MIN + CW'($urandom_range(0, 4095));
					cy = $urandom_range(0, 1) ? C_MAX - CW'($urandom_range(0, 4095))
						: C_MIN + CW'($urandom_range(0, 4095));
				end
				8: begin
					px = CW'($signed(11'($urandom)));
					py = CW'($signed(11'($urandom)));
					cx = CW'($signed(11'($urandom)));
					cy = CW'($signed(11'($urandom)));
				end
				9: begin
					case ($urandom_range(0, 4))
						0: ang = 0;
						1: ang = 16'h8000;
						2: ang = 16384;
						3: ang = -16'sd16384;
						default: ang = 32767;
					endcase
				end
				default: begin
				end
			endcase
			add_point(px, py, cx, cy, ang);
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (taken_count < sent_total)
			@(posedge clk);
		while (rotations_due.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("checked %0d rotated points, %0d of them saturated, %0d mismatches",
			checked_count, clipped_count, fail_count);
		$display("stimulus: field extremes, quadrant edges, half turn, random offsets and stalls");
		if (fail_count == 0) begin
			$display("point_rotate_about_center test passed");
		end else begin
			$display("point_rotate_about_center test failed");
		end
		$finish;
	end

endmodule

### sim.f
hdl/prc_pkg.sv
hdl/prc_cordic_stage.sv
hdl/prc_gain_fix.sv
hdl/point_rotate_about_center.sv
tb/tb.sv
